@@ rtl/srv_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, gains and register codes for the Schroeder reverb.
package srv_pkg;

  // internal arithmetic and storage widths
  localparam int SW = 40;  // working value width
  localparam int DW = 32;  // delay line entry width
  localparam int MA = 34;  // multiplier operand A
  localparam int MB = 24;  // multiplier operand B
  localparam int MP = MA + MB;

  localparam int GSH = 16;  // gains are Q0.16
  localparam int SMP_W = 16;
  localparam int PCT_W = 7;
  localparam int LEN_W = 17;
  localparam int NLINES = 7;
  localparam int NALLPASS = 3;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // floor(u / 100) = (u * RECIP_100) >> RECIP_SH, exact for u < 6.1e6
  localparam logic signed [MB-1:0] RECIP_100 = 24'sd5368710;
  localparam int RECIP_SH = 29;
  localparam int QUOT_W = 22;  // |num| >> FRAC_BITS stays below 2^22

  localparam logic signed [MB-1:0] G_AP = 24'sd45875;  // 0.7
  localparam logic signed [MB-1:0] K_AP = 24'sd33423;  // 1 - 0.49

  localparam logic signed [MB-1:0] COMB_GAIN [4] = '{
    24'sd50659, 24'sd52560, 24'sd49349, 24'sd48038
  };

  localparam logic [LEN_W-1:0] LEN_RESET [NLINES] = '{
    17'd347, 17'd113, 17'd37, 17'd1687, 17'd1601, 17'd2053, 17'd2251
  };

  localparam logic [2:0] CFG_DRY_WET = 3'd0;
  localparam logic [2:0] CFG_LEN_BASE = 3'd1;  // first line length register

endpackage

@@ rtl/srv_if.sv @@
`timescale 1ns / 1ps
// Stream interfaces for input frames and mixed output samples.
interface srv_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface srv_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] mixed_sample;
  modport source (output valid, output mixed_sample, input ready);
  modport sink (input valid, input mixed_sample, output ready);
endinterface

@@ rtl/srv_mul.sv @@
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
module srv_mul (
  input  logic                         clk,
  input  logic signed [srv_pkg::MA-1:0] a,
  input  logic signed [srv_pkg::MB-1:0] b,
  output logic signed [srv_pkg::MP-1:0] p
);
  import srv_pkg::*;

  logic signed [MP-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MP'(a) * MP'(b);
  end

  assign p = p_r;
endmodule

@@ rtl/srv_dline.sv @@
`timescale 1ns / 1ps
// Delay line storage: one write port, one registered read port.
module srv_dline #(
  parameter int AW = 19
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [srv_pkg::DW-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [srv_pkg::DW-1:0] rdata
);
  import srv_pkg::*;

  logic [DW-1:0] mem [0:(1<<AW)-1];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ rtl/schroeder_reverb_mono.sv @@
`timescale 1ns / 1ps
// Mono Schroeder reverb top level: sequencer around one multiplier and one line memory.
//
// Use: frames (left_sample, right_sample) come in on in_ch; one mixed_sample per
// frame leaves on out_ch. Both are valid/ready channels; a transfer happens on a
// clock edge with valid and ready high. cfg_we/cfg_index/cfg_wdata write the
// registers (0: dry_wet, 1..3: allpass lengths, 4..7: comb lengths), which the user
// must do only while idle; the block itself does not enforce it.
// Steps: a frame goes from its transfer until its result is loaded into the output
// register through S_POS, S_AQ, S_AT, S_AK, S_AY per allpass stage, S_POS, S_CB,
// S_CY per comb and S_M1 to S_M5 for the mix, all on the single shared multiplier,
// one product per cycle, and on the single line memory, one entry read per cycle.
// in_ch.ready is high only while the sequencer is idle: no frame is taken mid-sequence.
//
// Reset (rst_n low, synchronous) restores register defaults and then sweeps the
// line memory to zero, one entry a cycle, over all 8 * 2^clog2(MAX_DELAY) entries
// (524288 at the default). No frame is taken during the sweep; config writes are.
// A stalled receiver holds the result in the output register; the next frame may
// still be accepted and is held at its final step until the register frees up.
module schroeder_reverb_mono #(
  parameter int MAX_DELAY = 65536,
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  srv_in_if.sink                     in_ch,
  srv_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [srv_pkg::LEN_W-1:0]  cfg_wdata
);
  import srv_pkg::*;

  localparam int PW = $clog2(MAX_DELAY);      // position width
  localparam int LW = $clog2(MAX_DELAY + 1);  // effective length width
  localparam int AW = 3 + PW;                 // line memory address
  localparam logic signed [SW-1:0] LIM = SW'(64'(32767) << FRAC_BITS);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_POS  = 13'b0000000000010,
    S_AQ   = 13'b0000000000100,
    S_AT   = 13'b0000000001000,
    S_AK   = 13'b0000000010000,
    S_AY   = 13'b0000000100000,
    S_CB   = 13'b0000001000000,
    S_CY   = 13'b0000010000000,
    S_M1   = 13'b0000100000000,
    S_M2   = 13'b0001000000000,
    S_M3   = 13'b0010000000000,
    S_M4   = 13'b0100000000000,
    S_M5   = 13'b1000000000000
  } state_t;

  function automatic logic signed [SW-1:0] clip(input logic signed [SW-1:0] v);
    if (v > LIM) return LIM;
    if (v < -LIM) return -LIM;
    return v;
  endfunction

  function automatic logic signed [SW-1:0] mulg(input logic signed [MP-1:0] pr);
    return SW'(pr >>> GSH);
  endfunction

  state_t state_r, state_nxt;

  logic [PCT_W-1:0] dry_wet_r;
  logic [LEN_W-1:0] len_r [NLINES];
  logic [PW-1:0]    pos_r [NLINES];

  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;

  logic [2:0]           st_r;
  logic [PW-1:0]        p_r, q_r;
  logic signed [SW-1:0] x_r, dry_r, acc_r, lp_r, m1_r, p1_r;
  logic [QUOT_W-1:0]    u_r;
  logic                 neg_r;
  logic                 out_valid_r;
  logic signed [15:0]   out_data_r;

  // memory and multiplier hookup
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [DW-1:0]        mem_wdata;
  logic signed [DW-1:0] rd_data;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [MP-1:0] prod;

  srv_dline #(.AW(AW)) u_dline (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  srv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // position handling for the current line
  logic [LEN_W-1:0] len_sel;
  logic [LW-1:0]    n_eff, p_inc;
  logic [PW-1:0]    p_cur, q_cur, pos_next;
  logic [1:0]       cidx;
  logic             is_ap;

  always_comb begin
    len_sel = len_r[st_r];
    if (len_sel == '0) begin
      n_eff = LW'(1);
    end else if ({1'b0, len_sel} > 18'(MAX_DELAY)) begin
      n_eff = LW'(MAX_DELAY);
    end else begin
      n_eff = LW'(len_sel);
    end
    p_cur = (LW'(pos_r[st_r]) >= n_eff) ? '0 : pos_r[st_r];
    q_cur = (p_cur == '0) ? PW'(n_eff - LW'(1)) : p_cur - PW'(1);
    p_inc = LW'(p_cur) + LW'(1);
    pos_next = (p_inc >= n_eff) ? '0 : PW'(p_inc);
    cidx = 2'(st_r - 3'(NALLPASS));
    is_ap = (st_r < 3'(NALLPASS));
  end

  // datapath helpers
  logic [PCT_W-1:0]     w_eff;
  logic signed [SW-1:0] dry_in, comb_y, num, num_mag;
  logic [16:0]          quot, quot_s;

  always_comb begin
    w_eff = (dry_wet_r > PCT_FULL) ? PCT_FULL : dry_wet_r;
    dry_in = (SW'(SW'(in_ch.left_sample) + SW'(in_ch.right_sample)) <<< FRAC_BITS) >>> 1;
    comb_y = clip(m1_r + mulg(prod));
    num = p1_r + SW'(prod);
    num_mag = num[SW-1] ? -num : num;
    quot = prod[RECIP_SH+16:RECIP_SH];
    quot_s = neg_r ? -quot : quot;
  end

  always_comb begin
    state_nxt = state_r;
    mem_we = 1'b0;
    mem_waddr = {st_r, p_r};
    mem_wdata = '0;
    mem_raddr = {st_r, p_cur};
    mul_a = x_r[MA-1:0];
    mul_b = G_AP;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && !clr_busy_r) state_nxt = S_POS;
      end
      S_POS: begin
        mul_b = is_ap ? G_AP : COMB_GAIN[cidx];
        state_nxt = is_ap ? S_AQ : S_CB;
      end
      S_AQ: begin
        mem_raddr = {st_r, q_r};
        state_nxt = S_AT;
      end
      S_AT: begin
        mul_a = MA'(rd_data);
        state_nxt = S_AK;
      end
      S_AK: begin
        mul_a = MA'(lp_r - m1_r);
        mul_b = K_AP;
        mem_we = 1'b1;
        mem_wdata = DW'(mulg(prod) + m1_r);
        state_nxt = S_AY;
      end
      S_AY: state_nxt = S_POS;
      S_CB: begin
        mul_a = MA'(rd_data);
        mul_b = COMB_GAIN[cidx];
        mem_we = 1'b1;
        mem_wdata = x_r[DW-1:0];
        state_nxt = S_CY;
      end
      S_CY: state_nxt = (st_r == 3'(NLINES - 1)) ? S_M1 : S_POS;
      S_M1: begin
        mul_a = acc_r[MA-1:0];
        mul_b = {{(MB-PCT_W){1'b0}}, w_eff};
        state_nxt = S_M2;
      end
      S_M2: begin
        mul_a = dry_r[MA-1:0];
        mul_b = {{(MB-PCT_W){1'b0}}, PCT_FULL - w_eff};
        state_nxt = S_M3;
      end
      S_M3: state_nxt = S_M4;
      S_M4: begin
        mul_a = {{(MA-QUOT_W){1'b0}}, u_r};
        mul_b = RECIP_100;
        state_nxt = S_M5;
      end
      S_M5: begin
        // keep the quotient product steady while the output register is full
        mul_a = {{(MA-QUOT_W){1'b0}}, u_r};
        mul_b = RECIP_100;
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // reset sweep owns the write port
    if (clr_busy_r) begin
      mem_we = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      clr_busy_r <= 1'b1;
      clr_cnt_r <= '0;
      out_valid_r <= 1'b0;
      st_r <= '0;
      dry_wet_r <= '0;
      for (int i = 0; i < NLINES; i++) begin
        len_r[i] <= LEN_RESET[i];
        pos_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (&clr_cnt_r) clr_busy_r <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_DRY_WET) begin
          dry_wet_r <= cfg_wdata[PCT_W-1:0];
        end else begin
          len_r[cfg_index - CFG_LEN_BASE] <= cfg_wdata;
        end
      end
      if (out_valid_r && out_ch.ready && state_r != S_M5) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: st_r <= '0;
        S_POS: pos_r[st_r] <= pos_next;
        S_AY: st_r <= st_r + 3'd1;
        S_CY: if (st_r != 3'(NLINES - 1)) st_r <= st_r + 3'd1;
        S_M5: if (!out_valid_r || out_ch.ready) out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        x_r <= dry_in;
        dry_r <= dry_in;
      end
      S_POS: begin
        p_r <= p_cur;
        q_r <= q_cur;
      end
      S_AQ: begin
        lp_r <= SW'(rd_data);
        m1_r <= mulg(prod);
      end
      S_AY: x_r <= clip(mulg(prod));
      S_CB: m1_r <= mulg(prod);
      S_CY: acc_r <= (st_r == 3'(NALLPASS)) ? comb_y : clip(acc_r + comb_y);
      S_M2: p1_r <= SW'(prod);
      S_M3: begin
        neg_r <= num[SW-1];
        u_r <= QUOT_W'(num_mag >>> FRAC_BITS);
      end
      S_M5: if (!out_valid_r || out_ch.ready) out_data_r <= quot_s[15:0];
      default: ;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE) && !clr_busy_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.mixed_sample = out_data_r;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the mono Schroeder reverb: predictor, driver, monitor.
module testbench;
  import srv_pkg::*;

  localparam int LINE_DEPTH = 65536;
  localparam int FRAC = 8;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int LONG_HOLD = 600;

  // register indexes
  localparam logic [2:0] REG_DRY_WET = CFG_DRY_WET;
  localparam logic [2:0] REG_AP1 = CFG_LEN_BASE;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } frame_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [LEN_W-1:0] cfg_wdata;

  srv_in_if in_ch ();
  srv_out_if out_ch ();

  schroeder_reverb_mono u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of registers, delay lines and line positions.
  // ---------------------------------------------------------------------------
  int unsigned wet_pct;
  int unsigned line_len [NLINES];
  int unsigned line_pos [NLINES];
  int ap_mem [3][LINE_DEPTH];
  int cb_mem [4][LINE_DEPTH];

  frame_t pending_frames [$];
  logic signed [15:0] expected_mix [$];

  int errors;
  int frames_sent;
  int samples_checked;
  int cycle_count;
  bit no_idle;        // phase without any gaps on either side
  bit hold_request;   // asks the receiver for one long hold-off

  function automatic longint gain_mul(longint x, longint g);
    // floor of (x*g) / 2^16: arithmetic shift rounds toward minus infinity
    return (x * g) >>> GSH;
  endfunction

  function automatic longint sat_sample(longint v);
    longint lim;
    lim = longint'(32767) << FRAC;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic int unsigned used_len(int k);
    int unsigned n;
    n = line_len[k];
    if (n == 0) n = 1;
    if (n > LINE_DEPTH) n = LINE_DEPTH;
    return n;
  endfunction

  // current tap of line k, then step it with wrap at the length
  function automatic int unsigned next_tap(int k, int unsigned n);
    int unsigned p;
    p = line_pos[k];
    if (p >= n) p = 0;
    line_pos[k] = (p + 1 >= n) ? 0 : p + 1;
    return p;
  endfunction

  function automatic logic signed [15:0] reverb_predict(frame_t f);
    longint dry, v, y, acc, c, w, num;
    int unsigned n, p, q;
    dry = ((longint'(f.left_sample) + longint'(f.right_sample)) <<< FRAC) >>> 1;
    v = dry;
    for (int k = 0; k < NALLPASS; k++) begin
      n = used_len(k);
      p = next_tap(k, n);
      q = (p == 0) ? n - 1 : p - 1;
      y = gain_mul(longint'(ap_mem[k][p]) - gain_mul(v, longint'(G_AP)), longint'(K_AP));
      ap_mem[k][p] = int'(gain_mul(longint'(ap_mem[k][q]), longint'(G_AP)) +
                          gain_mul(v, longint'(G_AP)));
      v = sat_sample(y);
    end
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      n = used_len(NALLPASS + k);
      p = next_tap(NALLPASS + k, n);
      c = gain_mul(v, longint'(COMB_GAIN[k])) +
          gain_mul(longint'(cb_mem[k][p]), longint'(COMB_GAIN[k]));
      cb_mem[k][p] = int'(v);
      c = sat_sample(c);
      acc = (k == 0) ? c : sat_sample(acc + c);
    end
    w = (wet_pct > 100) ? 100 : wet_pct;
    num = acc * w + dry * (100 - w);
    // SystemVerilog division truncates toward zero
    return 16'(num / (longint'(100) << FRAC));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feeds frames from the pending queue with random gaps.
  // ---------------------------------------------------------------------------
  int gap_left;

  always @(posedge clk) begin
    bit took;
    frame_t f;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.left_sample <= '0;
      in_ch.right_sample <= '0;
      gap_left <= 0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        f.left_sample = in_ch.left_sample;
        f.right_sample = in_ch.right_sample;
        expected_mix.push_back(reverb_predict(f));
        frames_sent++;
      end
      if (in_ch.valid && !took) begin
        // hold the frame until the transfer
      end else if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_frames.size() > 0) begin
        f = pending_frames.pop_front();
        in_ch.left_sample <= f.left_sample;
        in_ch.right_sample <= f.right_sample;
        in_ch.valid <= 1'b1;
        gap_left <= no_idle ? 0 : $urandom_range(0, 3);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per sample plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  int stall_left;
  int hold_left;
  bit hold_done;

  always @(posedge clk) begin
    int stall_pick;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (no_idle) begin
        out_ch.ready <= 1'b1;
        stall_left <= 0;
      end else begin
        stall_pick = $urandom_range(0, 3);
        stall_left <= (stall_pick > 0) ? stall_pick - 1 : 0;
        out_ch.ready <= (stall_pick == 0);
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: each mixed sample against the oldest prediction.
  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_mix.size() == 0) begin
        $error("mixed_sample: unexpected transfer, value %0d", out_ch.mixed_sample);
        errors++;
      end else begin
        want = expected_mix.pop_front();
        samples_checked++;
        if (out_ch.mixed_sample !== want) begin
          $error("mixed_sample: expected %0d, actual %0d", want, out_ch.mixed_sample);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= LEN_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    // block is idle, so the write applies to the predictor right away
    if (idx == REG_DRY_WET) wet_pct = val & 7'h7F;
    else line_len[idx - REG_AP1] = val & 17'h1FFFF;
  endtask

  task automatic set_lengths(int unsigned a1, int unsigned a2, int unsigned a3,
                             int unsigned c1, int unsigned c2, int unsigned c3,
                             int unsigned c4);
    int unsigned v [NLINES];
    v = '{a1, a2, a3, c1, c2, c3, c4};
    for (int k = 0; k < NLINES; k++) write_reg(REG_AP1 + 3'(k), v[k]);
  endtask

  task automatic queue_frame(int l, int r);
    frame_t f;
    f.left_sample = 16'(l);
    f.right_sample = 16'(r);
    pending_frames.push_back(f);
  endtask

  // mostly random content, some full scale frames to push the clipping
  task automatic queue_random(int count);
    int l, r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        l = $urandom_range(0, 1) ? 32767 : -32768;
        r = $urandom_range(0, 3) == 0 ? -l - 1 : l;
      end else begin
        l = $urandom_range(0, 65535) - 32768;
        r = $urandom_range(0, 1) ? l : $urandom_range(0, 65535) - 32768;
      end
      queue_frame(l, r);
    end
  endtask

  task automatic drain();
    while (pending_frames.size() > 0 || in_ch.valid || expected_mix.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    frames_sent = 0;
    samples_checked = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    hold_request = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    wet_pct = 0;
    for (int k = 0; k < NLINES; k++) begin
      line_len[k] = LEN_RESET[k];
      line_pos[k] = 0;
    end
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full wet, tiny lines including length one
    write_reg(REG_DRY_WET, 100);
    set_lengths(1, 2, 3, 1, 2, 3, 4);
    queue_frame(32767, 32767);
    queue_frame(-32768, -32768);
    queue_frame(32767, -32768);
    queue_frame(-32768, 32767);
    queue_frame(0, 0);
    queue_frame(1, 0);
    queue_frame(-1, 0);
    queue_frame(-1, -1);
    queue_frame(16'h5555, 16'hAAAA);
    queue_frame(16'hAAAA, 16'h5555);
    for (int i = 0; i < 6; i++) queue_frame(32767, 32767);
    for (int i = 0; i < 6; i++) queue_frame(-32768, -32768);
    drain();

    // Out of range settings: wet above 100, length zero, length above the line
    write_reg(REG_DRY_WET, 127);
    set_lengths(0, 131071, 65536, 0, 65536, 131071, 65535);
    queue_random(150);
    hold_request = 1'b1;   // long receiver hold-off while frames keep coming
    drain();

    // Short random lines, half wet, no idling on either side
    no_idle = 1'b1;
    write_reg(REG_DRY_WET, 50);
    set_lengths($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                $urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                $urandom_range(1, 64));
    queue_random(200);
    drain();
    no_idle = 1'b0;

    // Lowered lengths leave positions beyond the end; fully dry mix
    write_reg(REG_DRY_WET, 0);
    set_lengths(3, 2, 1, 5, 1, 7, 2);
    queue_random(150);
    drain();

    // Default-like lengths, random wet share
    write_reg(REG_DRY_WET, $urandom_range(1, 99));
    set_lengths(347, 113, 37, 1687, 1601, 2053, 2251);
    queue_random(130);
    drain();

    $display("%0d frames sent, %0d mixed samples checked over five register settings",
             frames_sent, samples_checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/srv_pkg.sv
rtl/srv_if.sv
rtl/srv_mul.sv
rtl/srv_dline.sv
rtl/schroeder_reverb_mono.sv
test/testbench.sv
